### hdl/lfg_pkg.sv
// ----------------------------------------------------------------------------
// lfg_pkg: shared types and constants of the lagged-Fibonacci generator
// Ring geometry, Lehmer seeding constants, request codes, sequencer states
// and the 607-word warm-up table.
// ----------------------------------------------------------------------------
package lfg_pkg;

  localparam int RING_LEN  = 607;
  localparam int SHORT_LAG = 273;
  localparam int LONG_RST  = RING_LEN - SHORT_LAG;
  localparam int PTR_W     = $clog2(RING_LEN);
  localparam int WORD_W    = 63;
  localparam int SEED_W    = 64;

  localparam int LEH_W      = 31;
  localparam int LEH_MUL_W  = 16;
  localparam int PROD_W     = LEH_W + LEH_MUL_W;
  localparam logic [LEH_MUL_W-1:0] LEH_MUL = 16'd48271;
  localparam logic [LEH_W-1:0] LEH_MOD     = 31'h7FFF_FFFF;
  localparam logic [LEH_W-1:0] SEED_SUBST  = 31'd89482311;
  localparam int WARMUP_STEPS = 20;
  localparam int WARM_CNT_W   = $clog2(WARMUP_STEPS + 1);

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic {
    REQ_SEED = 1'b0,
    REQ_DRAW = 1'b1
  } lfg_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FOLD,
    ST_MUL,
    ST_MOD
  } lfg_state_t;

  typedef enum logic [1:0] {
    PH_HIGH,
    PH_MID,
    PH_LOW
  } lfg_phase_t;

  localparam word_t WARM_ROM [RING_LEN] = '{
  63'd5041579894721019882,63'd4646389086726545243,63'd1395769623340756751,63'd5333664234075297259,
  63'd2875692520355975054,63'd9033628115061424579,63'd7143218595135194537,63'd4812947590706362721,
  63'd793725219434979937,63'd530729988033884841,63'd820934885176392507,63'd211574159931881404,
  63'd459301545753085629,63'd814087573554188801,63'd331942924126508902,63'd861981564819032103,
  63'd172707404348361950,63'd11310849972103861,63'd456951997145934558,63'd506283385907531473,
  63'd238761877125906442,63'd271613134435668611,63'd655939277482587688,63'd765009320169237031,
  63'd768432388404375216,63'd25786783599603139,63'd659345651940901516,63'd27132751497369789,
  63'd278938644734011828,63'd106519279724614962,63'd334450788199935639,63'd445979794178006663,
  63'd746508166272859988,63'd101495080555509718,63'd444944072934599077,63'd348110936643850264,
  63'd241867278911088838,63'd579656288757629477,63'd448426606444954017,63'd373898236197178704,
  63'd452359718451235442,63'd1053050805812849,63'd863383378328234611,63'd262530992962879162,
  63'd866040596524588430,63'd1016283250897194,63'd654071468096181739,63'd703180231278462085,
  63'd624091127734594466,63'd83186435546080105,63'd800443413754215289,63'd211628725166105215,
  63'd220230980099216696,63'd916102036694505356,63'd406929955240776386,63'd493638353799262244,
  63'd45735150513152492,63'd34219504592817935,63'd284777168281660050,63'd206802011598637651,
  63'd436864998958802106,63'd88723158709518525,63'd556359150688657649,63'd681622520025195029,
  63'd561697278703408604,63'd847180930339483656,63'd168657502164118685,63'd404548433807426200,
  63'd424415621520177892,63'd784821733378357738,63'd563213652104976190,63'd83328314205783527,
  63'd902972650836907719,63'd324358313466408729,63'd431637110180447708,63'd893784997996599798,
  63'd644694040681043410,63'd167934209233237473,63'd605063846074242207,63'd699352071950958158,
  63'd764087785251429360,63'd588135342628590798,63'd81278655075686088,63'd454184558448334333,
  63'd272547021627700908,63'd498067566014685372,63'd521076908060323606,63'd889428331899053082,
  63'd632644280475008428,63'd149581284368424392,63'd706975157879912801,63'd737025729186023086,
  63'd675692927535694226,63'd470679451163387365,63'd782452046782789866,63'd854987509054245321,
  63'd3365082947859615,63'd132891843575132264,63'd729790260180362445,63'd101119018391885749,
  63'd223802503681785494,63'd514715999747391035,63'd89651209156052298,63'd265947084928637994,
  63'd609772935839344860,63'd173172598630475368,63'd410625584198381271,63'd832715521072153550,
  63'd847751162068607440,63'd580387604467576223,63'd843541778086022166,63'd598885285665107124,
  63'd471583729710395191,63'd756617197126448511,63'd50580856267889561,63'd507009818069506337,
  63'd84211066677587151,63'd57215682502567780,63'd179188101349234089,63'd339326709486603876,
  63'd377872185047223650,63'd235276948318620127,63'd129245958384736745,63'd889790704367508841,
  63'd578180903714416353,63'd273395879402949251,63'd509201968868075469,63'd899612455477252684,
  63'd423473717318623208,63'd502755828727547283,63'd463519858634477230,63'd868733889326713935,
  63'd590750815073040738,63'd78475625547394445,63'd97239292751482990,63'd542205769480817511,
  63'd515842064296928389,63'd904853167855864322,63'd240721114669887710,63'd758328221652109956,
  63'd394079651453096228,63'd334117463104520637,63'd309531388958610294,63'd740532189568823871,
  63'd583208013294717528,63'd789006487514591966,63'd818413921079958319,63'd114985986140922613,
  63'd146459724384021130,63'd464164800718799187,63'd351649188547146689,63'd95628852179165769,
  63'd665708996501465751,63'd522088435888797935,63'd179667732647462064,63'd534076197064893291,
  63'd114797717161418156,63'd506603746554825232,63'd257476591183785984,63'd108584827984520477,
  63'd335010752986839035,63'd611643869436655849,63'd210770107597129381,63'd180329406592126926,
  63'd246947805417555887,63'd736824328101996598,63'd379190836784367752,63'd18504697111645663,
  63'd225709575651343964,63'd721769397107746012,63'd90904995307950425,63'd719664926854522426,
  63'd563766034540086959,63'd395554494542796518,63'd805752865091741896,63'd413926844030112764,
  63'd662192658851356805,63'd137336113680268144,63'd652736623138360001,63'd350765457516270089,
  63'd920205851277472985,63'd195481837689158554,63'd664038090713017570,63'd829956331917823568,
  63'd390186735521895437,63'd704631074229557406,63'd684719539133399023,63'd157263810051886805,
  63'd885042267011839972,63'd363190914229199290,63'd515888109195083128,63'd288295831734312159,
  63'd476325893181581640,63'd628005273434178534,63'd424378940820496485,63'd204346472802082797,
  63'd654530046602208546,63'd456258037575859816,63'd549545116879542735,63'd173831286159015109,
  63'd55300461875781649,63'd689516063275795982,63'd823362392226468517,63'd713950633880136085,
  63'd855089122238799166,63'd553566868813930554,63'd243093385335025624,63'd540194125786320107,
  63'd815964003910772879,63'd615749383160077036,63'd763206628365814375,63'd630832838161710334,
  63'd368187876408614036,63'd328968613719010974,63'd658799720061108684,63'd24471477425813547,
  63'd407978837741713610,63'd809030257594462433,63'd294511736343135636,63'd86432439584874104,
  63'd300903926031262070,63'd843002746008253403,63'd40108470004599334,63'd725462244643869492,
  63'd470786415956358861,63'd564024853096349395,63'd598250771268999789,63'd331509824228221010,
  63'd550384757877191842,63'd394197136717519388,63'd811856658030479807,63'd383926127401987129,
  63'd706241041174209084,63'd74138100298020766,63'd602799412969025081,63'd249782999415006393,
  63'd625139033442622883,63'd136893024790351883,63'd880909639931638024,63'd649200435039190070,
  63'd246214573746348963,63'd40482841892029917,63'd415302643423169059,63'd26178571525547594,
  63'd546471538460007135,63'd59271040437876301,63'd676412923665775122,63'd851365571853935744,
  63'd582034366380191420,63'd38529852468378991,63'd522413500343819946,63'd630313164133880214,
  63'd715012256130937139,63'd36810789914067375,63'd311518683455831155,63'd291563635358428105,
  63'd478258389462771827,63'd671829230069998958,63'd838708518691437522,63'd338751313202475628,
  63'd465432937543253823,63'd893066756136338160,63'd537437343687631927,63'd762304235048345395,
  63'd772544290181326332,63'd918622546756158725,63'd409102728959750335,63'd235763160649257980,
  63'd253093682005861183,63'd163655187624004363,63'd556466467433496579,63'd145224414533431625,
  63'd206164238101969082,63'd127958026649529403,63'd910848158317122100,63'd602327868673404980,
  63'd500763003267697334,63'd215316879295258978,63'd672033453496475053,63'd604154649113479410,
  63'd343392240928378630,63'd228547992279730091,63'd311061494089657613,63'd636655959072284289,
  63'd541879141966613650,63'd716329841964354375,63'd489113805392369699,63'd58061851027790701,
  63'd168403406525168676,63'd442951476735729584,63'd33034657855545000,63'd111963799581217467,
  63'd717751527165346013,63'd458904224847080025,63'd769328862905900456,63'd14360704525844422,
  63'd24699430589627362,63'd86641732480309928,63'd647354711056581607,63'd309237993620887689,
  63'd205842783951375405,63'd513378470852686793,63'd878588255630128124,63'd614933266684116761,
  63'd858584218145447213,63'd613767834780551127,63'd207044718443697000,63'd570822342770557654,
  63'd599965789245824450,63'd435839141178901242,63'd32512300870838984,63'd683762169388729092,
  63'd484372190531562700,63'd601065122214927641,63'd539835219896387465,63'd460202599011425098,
  63'd104464635256904880,63'd910661415985316167,63'd82925611522859326,63'd491928436910299700,
  63'd268153255764685089,63'd368155947248851187,63'd530799951895821403,63'd633413038844282927,
  63'd265870823291653760,63'd116331386505218628,63'd58194533750952067,63'd364877892071864790,
  63'd442367324630654441,63'd162079978399695574,63'd22082801340951594,63'd815038469999938976,
  63'd428736051829675300,63'd459000018484588384,63'd551366085726108518,63'd696482910039277427,
  63'd47899168835077603,63'd874614018568564878,63'd22850009133442024,63'd135618700745730223,
  63'd301925399203419458,63'd315260160567850000,63'd43015275270600221,63'd555958155369697117,
  63'd491643298536927566,63'd66357493173455439,63'd342077383892773207,63'd286834862257991557,
  63'd199931913404441852,63'd332868951863628272,63'd258767270978137117,63'd151725531352939933,
  63'd309234395631736248,63'd366225251900706410,63'd97244559919649811,63'd766486543587595936,
  63'd170891353348228256,63'd691781716266886849,63'd321762902254531290,63'd257004302722170710,
  63'd873978883954362461,63'd248807592462135281,63'd469400239538743666,63'd455962848179851435,
  63'd299720396615329810,63'd128255937302635449,63'd24011314314667438,63'd866571332924651644,
  63'd62814133176634675,63'd457195081718677047,63'd147281118815223540,63'd759664802601035582,
  63'd609121941775442474,63'd783416186482816406,63'd710344551887725490,63'd439086123735745920,
  63'd444265386424057173,63'd890348240484733136,63'd62226169949417364,63'd603726125029721324,
  63'd50440494806570911,63'd727521552621711306,63'd101117678085600140,63'd219475010562346106,
  63'd262307182861523480,63'd515731372807383610,63'd373840511196660204,63'd253976752407672957,
  63'd246728439634926934,63'd525602699053685186,63'd784108688862839610,63'd664085753865589316,
  63'd120208733903831749,63'd211351499244071597,63'd753435089534293140,63'd492528473489848474,
  63'd514562377147749380,63'd822514088013497233,63'd271952035438405053,63'd913234669781551377,
  63'd433215449571016377,63'd713778959409434691,63'd699472109134426883,63'd666722857486904893,
  63'd65544004572667749,63'd5993474729846685,63'd612497402807803640,63'd895777478065536541,
  63'd233220607194246643,63'd170105671228636962,63'd315489738361863650,63'd163776618138760752,
  63'd246052127776757653,63'd19730939350268413,63'd64367785438526731,63'd254317930786193485,
  63'd435076901020748511,63'd475465208941066767,63'd201559550264151451,63'd799905945897645860,
  63'd428794607148084081,63'd836268636677030897,63'd648646920932173215,63'd361772784584179602,
  63'd755435352583430224,63'd445002265515354236,63'd160519574021353574,63'd532701456530550838,
  63'd462657581355032832,63'd269222202059770514,63'd24104557371724986,63'd509804697462709401,
  63'd791688229546073026,63'd88481709029753057,63'd532916040953063059,63'd779097952885772613,
  63'd495507023805937340,63'd491853727542267430,63'd300807618395040462,63'd300776922607115790,
  63'd247034623561780302,63'd892870277269673173,63'd785618792021444590,63'd447487458539197488,
  63'd790017666060071091,63'd214057112791622667,63'd242544505726519997,63'd248605515334184783,
  63'd418667009438202579,63'd188393900744603504,63'd880866604407486798,63'd373413424117847925,
  63'd406596887136008919,63'd695312420038584778,63'd130568681473889905,63'd163773909901445764,
  63'd365612566094799320,63'd396675963463316702,63'd310637820408855633,63'd632889982277844981,
  63'd456538510544025295,63'd197988428953949380,63'd233179318692086542,63'd378320669420892258,
  63'd846496120980233608,63'd284396375160957768,63'd303067819548489632,63'd479371757409577260,
  63'd445923949480816288,63'd40258789580008723,63'd805789140871116751,63'd454188817093898507,
  63'd104266227290881681,63'd555730305712256895,63'd264767872628324998,63'd214447744154983376,
  63'd580635221535538708,63'd711777100347390362,63'd591659717770854163,63'd46259771545232136,
  63'd883365809702575878,63'd597027348142531530,63'd56381311938173130,63'd276834955065269701,
  63'd159882820625087386,63'd520639364740355811,63'd623504348570926182,63'd315221740201463949,
  63'd846969326727406649,63'd12567292024180741,63'd531107962402406093,63'd666375493231049158,
  63'd873684829504875171,63'd448803977499206187,63'd592330282348732710,63'd14089179108310323,
  63'd741494279339357429,63'd799042078089695739,63'd431781739280707670,63'd362518436970536734,
  63'd274072276528812270,63'd574310000970275834,63'd599789864050903915,63'd885449334135248416,
  63'd524220803543290780,63'd70133889989098719,63'd760928042919751410,63'd302098575511233416,
  63'd665132270705551286,63'd263519572362116061,63'd514452086424602881,63'd103508651572782982,
  63'd156724209711638904,63'd817238926019163658,63'd633782035142929227,63'd216301256699645892,
  63'd274319090289026268,63'd190636763322132342,63'd601154491566359813,63'd593225530735261076,
  63'd224112846040631545,63'd89550489621669558,63'd309448300311137271,63'd458385746029296310,
  63'd907988717165659497,63'd883928918193071140,63'd576274038724305787,63'd422507205534802623,
  63'd183822059838903306,63'd380162033680158041,63'd882352662008007385,63'd177661760558510033,
  63'd789905501887764262,63'd542167976146300304,63'd552110296308627512,63'd424827944355936589,
  63'd873548753090509853,63'd176052709157369297,63'd714248504965774589,63'd822265687292721812,
  63'd496953156492370432,63'd339447594219687248,63'd642417445326033814,63'd35924854507493288,
  63'd327365128283173059,63'd679710619979713859,63'd303091821766509321,63'd14560083461731403,
  63'd603657585606562623,63'd74041625163452715,63'd708042763544993558,63'd695178137086833547,
  63'd39992272236368792,63'd29490231444725318,63'd784495093633917852,63'd88032085863470904,
  63'd619265568080867557,63'd41160468638471038,63'd902680844036512446,63'd644078355749758773,
  63'd461567463472240429,63'd53989729044158054,63'd209623822586688385,63'd875195563940818268,
  63'd190722490805228960,63'd738103975730176855,63'd615723851339323965,63'd774999423191415757,
  63'd862957160438089275,63'd528043303123908147,63'd710161189013981325,63'd247901853798576783,
  63'd716917692441276957,63'd794206649779320330,63'd135775972905555768,63'd227844743945117484,
  63'd362533878574388065,63'd647747953900670852,63'd897618537557927220,63'd551137155471183612,
  63'd132602418052089084,63'd753744987659604882,63'd546468020349969615,63'd318967118316219604,
  63'd634675175356585710,63'd24115998732063030,63'd309579344965868205,63'd897833284673631015,
  63'd290279466227314721,63'd720869853019062969,63'd727690179233934373,63'd173238522931444314,
  63'd413329215417082838,63'd291830869822419454,63'd151946139793714445,63'd529393471261659176,
  63'd492282895402345266,63'd287921153349642564,63'd589623639644347210,63'd846504381535175242,
  63'd732902039687162474,63'd891547171701448858,63'd294490263567746304,63'd705207907349346513,
  63'd838214293518882402,63'd910392286078035154,63'd4152330101494654406
  };

endpackage

### hdl/lfg_ifs.sv
// ----------------------------------------------------------------------------
// lfg_ifs: stream channels of the lagged-Fibonacci generator
// Request channel (reseed or draw) and result channel, valid/ready each.
// ----------------------------------------------------------------------------
interface lfg_in_if;
  import lfg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic signed [SEED_W-1:0] seed_value;

  modport source (output valid, req_type, seed_value, input ready);
  modport sink   (input valid, req_type, seed_value, output ready);
endinterface

interface lfg_out_if;
  import lfg_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_value;

  modport source (output valid, random_value, input ready);
  modport sink   (input valid, random_value, output ready);
endinterface

### hdl/lagged_fibonacci_random_generator.sv
// ----------------------------------------------------------------------------
// lagged_fibonacci_random_generator: additive lagged-Fibonacci generator
// 607-word ring in a synchronous RAM with a tap at lag 273; a Lehmer-seeded
// fill sequencer loads the ring on every reseed request.
// ----------------------------------------------------------------------------
//  channel   | dir | signals                         | meaning
//  ----------+-----+---------------------------------+--------------------------
//  in_chan   | in  | valid ready req_type seed_value | 0: reseed, 1: draw
//  out_chan  | out | valid ready random_value        | one 63-bit word per draw
//
//  Draw: ring read, then add and write-back; a new draw is taken every
//  cycle while results drain, with a two-entry result buffer between the
//  ring pipeline and out_chan.
//  Reseed: seed fold, then 20 warm-up and 1821 fill Lehmer steps, each a
//  multiply and a reduction on the single multiplier; in_chan stalls.
//  Reset clears pointers and control only; ring contents are undefined until
//  the first reseed.
// ----------------------------------------------------------------------------
module lagged_fibonacci_random_generator (
  input logic     clk,
  input logic     rst_n,
  lfg_in_if.sink  in_chan,
  lfg_out_if.source out_chan
);
  import lfg_pkg::*;

  function automatic ptr_t step_down(input ptr_t p);
    ptr_t res;
    if (p == '0 || p >= PTR_W'(RING_LEN)) res = PTR_W'(RING_LEN - 1);
    else                                   res = p - 1'b1;
    return res;
  endfunction

  // ring storage
  word_t ring_mem [RING_LEN];

  lfg_state_t state_r, state_nxt;

  ptr_t  sptr_r, lptr_r;
  ptr_t  sptr_step, lptr_step;
  logic  rd_vld_r;
  ptr_t  wr_addr_r;
  word_t q_s_r, q_l_r;
  word_t draw_sum;

  logic  out_vld_r, out_vld_nxt;
  word_t out_dat_r, out_dat_nxt;
  logic  skid_vld_r, skid_vld_nxt;
  word_t skid_dat_r, skid_dat_nxt;
  logic  pop;
  logic [1:0] occ;

  logic  in_acc, draw_acc, seed_acc;
  logic  in_rdy;
  logic  fill_we;

  // seeding datapath
  logic [SEED_W-1:0]      fold_r;
  logic [SEED_W-1:0]      fold_sum;
  logic                   neg_r;
  logic [LEH_W-1:0]       red_pos, red_adj, seed_x;
  logic [LEH_W-1:0]       x_r;
  logic [PROD_W-1:0]      prod_r;
  logic [LEH_W:0]         leh_t;
  logic [LEH_W-1:0]       leh_x;
  logic [WARM_CNT_W-1:0]  warm_cnt_r;
  lfg_phase_t             phase_r;
  ptr_t                   fill_idx_r;
  word_t                  acc_r, rom_q_r, fill_word;
  logic                   warm_done, fold_done, last_word;

  ptr_t  ring_waddr;
  word_t ring_wdata;

  // --------------------------------------------------------------------------
  // handshake and occupancy
  // --------------------------------------------------------------------------
  assign pop      = out_vld_r && out_chan.ready;
  assign occ      = 2'(rd_vld_r) + 2'(out_vld_r) + 2'(skid_vld_r);
  assign in_acc   = in_chan.valid && in_rdy;
  assign draw_acc = in_acc && (in_chan.req_type == REQ_DRAW);
  assign seed_acc = in_acc && (in_chan.req_type == REQ_SEED);

  assign sptr_step = step_down(sptr_r);
  assign lptr_step = step_down(lptr_r);
  assign draw_sum  = q_l_r + q_s_r;

  // --------------------------------------------------------------------------
  // seed reduction mod 2^31-1: fold 31-bit digits, then correct for sign
  // (2^64 is 4 modulo 2^31-1)
  // --------------------------------------------------------------------------
  assign fold_sum  = {33'b0, fold_r[LEH_W-1:0]} + {31'b0, fold_r[SEED_W-1:LEH_W]};
  assign fold_done = (fold_r[SEED_W-1:LEH_W] == '0);

  always_comb begin
    red_pos = (fold_r[LEH_W-1:0] == LEH_MOD) ? '0 : fold_r[LEH_W-1:0];
    if (!neg_r)                    red_adj = red_pos;
    else if (red_pos >= 31'd4)     red_adj = red_pos - 31'd4;
    else                           red_adj = red_pos + (LEH_MOD - 31'd4);
    seed_x = (red_adj == '0) ? SEED_SUBST : red_adj;
  end

  // Lehmer step back half: x*48271 mod 2^31-1 by one fold and one subtract
  assign leh_t = {1'b0, prod_r[LEH_W-1:0]} + {16'b0, prod_r[PROD_W-1:LEH_W]};
  assign leh_x = (leh_t >= {1'b0, LEH_MOD}) ? LEH_W'(leh_t - {1'b0, LEH_MOD})
                                            : leh_t[LEH_W-1:0];

  assign warm_done = (warm_cnt_r == WARM_CNT_W'(WARMUP_STEPS));
  assign last_word = (fill_idx_r == PTR_W'(RING_LEN - 1));
  assign fill_word = acc_r ^ {32'b0, leh_x} ^ rom_q_r;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (seed_acc) state_nxt = ST_FOLD;
      ST_FOLD: if (fold_done) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_MOD;
      ST_MOD: begin
        if (warm_done && phase_r == PH_LOW && last_word) state_nxt = ST_IDLE;
        else                                             state_nxt = ST_MUL;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_rdy  = 1'b0;
    fill_we = 1'b0;
    unique case (state_r)
      ST_IDLE: in_rdy  = (occ - 2'(pop)) <= 2'd1;
      ST_MOD:  fill_we = warm_done && (phase_r == PH_LOW);
      default: ;
    endcase
  end

  assign in_chan.ready = in_rdy;

  // --------------------------------------------------------------------------
  // result buffer: output register plus skid entry
  // --------------------------------------------------------------------------
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_dat_nxt  = out_dat_r;
    skid_vld_nxt = skid_vld_r;
    skid_dat_nxt = skid_dat_r;
    if (pop) begin
      if (skid_vld_r) begin
        out_dat_nxt  = skid_dat_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
    if (rd_vld_r) begin
      if (!out_vld_nxt) begin
        out_vld_nxt = 1'b1;
        out_dat_nxt = draw_sum;
      end else begin
        skid_vld_nxt = 1'b1;
        skid_dat_nxt = draw_sum;
      end
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.random_value = out_dat_r;

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      sptr_r     <= '0;
      lptr_r     <= PTR_W'(LONG_RST);
      rd_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_vld_r   <= draw_acc;
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
      if (seed_acc) begin
        sptr_r <= '0;
        lptr_r <= PTR_W'(LONG_RST);
      end else if (draw_acc) begin
        sptr_r <= sptr_step;
        lptr_r <= lptr_step;
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    out_dat_r  <= out_dat_nxt;
    skid_dat_r <= skid_dat_nxt;
    rom_q_r    <= WARM_ROM[fill_idx_r];
    if (draw_acc) wr_addr_r <= lptr_step;
    if (seed_acc) begin
      fold_r <= in_chan.seed_value;
      neg_r  <= in_chan.seed_value[SEED_W-1];
    end
    unique case (state_r)
      ST_FOLD: begin
        if (fold_done) begin
          x_r        <= seed_x;
          warm_cnt_r <= '0;
          phase_r    <= PH_HIGH;
          fill_idx_r <= '0;
        end else begin
          fold_r <= fold_sum;
        end
      end
      ST_MUL: prod_r <= PROD_W'(x_r) * PROD_W'(LEH_MUL);
      ST_MOD: begin
        x_r <= leh_x;
        if (!warm_done) begin
          warm_cnt_r <= warm_cnt_r + 1'b1;
        end else begin
          unique case (phase_r)
            PH_HIGH: begin
              acc_r   <= {leh_x[WORD_W-41:0], 40'b0};
              phase_r <= PH_MID;
            end
            PH_MID: begin
              acc_r   <= acc_r ^ {12'b0, leh_x, 20'b0};
              phase_r <= PH_LOW;
            end
            PH_LOW: begin
              phase_r    <= PH_HIGH;
              fill_idx_r <= fill_idx_r + 1'b1;
            end
            default: phase_r <= PH_HIGH;
          endcase
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // ring RAM: one write port, two registered read ports
  // --------------------------------------------------------------------------
  assign ring_waddr = rd_vld_r ? wr_addr_r : fill_idx_r;
  assign ring_wdata = rd_vld_r ? draw_sum  : fill_word;

  always_ff @(posedge clk) begin
    if (rd_vld_r || fill_we) ring_mem[ring_waddr] <= ring_wdata;
    if (draw_acc) begin
      q_s_r <= ring_mem[sptr_step];
      q_l_r <= ring_mem[lptr_step];
    end
  end

`ifndef SYNTHESIS
  // feed and tap pointers keep their fixed distance
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (lptr_r - sptr_r) == PTR_W'(LONG_RST) ||
    (lptr_r + PTR_W'(RING_LEN) - sptr_r) == PTR_W'(LONG_RST))
    else $error("ring pointer distance lost");

  // write-back of one draw never hits a word read by the next
  a_no_raw: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r && draw_acc |-> wr_addr_r != sptr_step && wr_addr_r != lptr_step)
    else $error("draw read overlaps pending write-back");

  // fill writes and draw write-backs never share the port
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    fill_we |-> !rd_vld_r)
    else $error("ring write port collision");

  // skid entry is used only behind a full output register
  a_skid: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry valid with empty output register");

  // a draw in flight always finds room in the result buffer
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> !(skid_vld_r && !pop))
    else $error("result buffer overflow");

  // no request taken while the ring is being filled
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_chan.ready)
    else $error("request accepted during reseed");
`endif

endmodule

### tb/lagged_fibonacci_random_generator_tb.sv
// ----------------------------------------------------------------------------
// lagged_fibonacci_random_generator_tb: self-checking bench for the generator
// Sends reseed and draw requests with random gaps and checks every drawn word
// against a ring model in the bench. The ring is reloaded from a Lehmer
// sequence on each reseed. The result side stalls at random, with one long
// hold-off that fills the block.
// ----------------------------------------------------------------------------
module lagged_fibonacci_random_generator_tb;
  import lfg_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_ITEMS     = 1200;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    lfg_req_t          kind;
    logic [SEED_W-1:0] seed;
  } req_item_t;

  logic clk;
  logic rst_n;

  lfg_in_if  in_chan ();
  lfg_out_if out_chan ();

  lagged_fibonacci_random_generator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // ring model
  word_t lag_ring [RING_LEN];
  ptr_t  tap_ptr;
  ptr_t  feed_ptr;

  req_item_t request_q [$];
  word_t     pending_draws [$];

  int err_cnt;
  int n_in_taken;
  int idle_cycles;
  bit in_took;
  bit out_took;
  int send_gap;
  int send_calm;
  int rx_stall;
  int rx_calm;
  int hold_left;
  bit hold_done;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [LEH_W-1:0] lehmer(input logic [LEH_W-1:0] x);
    logic [63:0] p;
    p = 64'(x) * 64'(LEH_MUL);
    return LEH_W'(p % 64'(LEH_MOD));
  endfunction

  // residue in [0, M-1] for the signed seed, zero replaced by the fixed value
  function automatic logic [LEH_W-1:0] fold_seed(input logic [SEED_W-1:0] s);
    logic [63:0] r;
    if (s[SEED_W-1]) begin
      r = (~s + 64'd1) % 64'(LEH_MOD);
      if (r != 0) r = 64'(LEH_MOD) - r;
    end else begin
      r = s % 64'(LEH_MOD);
    end
    if (r == 0) r = 64'(SEED_SUBST);
    return LEH_W'(r);
  endfunction

  task automatic reload_ring(input logic [SEED_W-1:0] s);
    logic [LEH_W-1:0] x;
    logic [63:0]      w;
    x = fold_seed(s);
    tap_ptr  = '0;
    feed_ptr = ptr_t'(LONG_RST);
    repeat (WARMUP_STEPS) x = lehmer(x);
    for (int i = 0; i < RING_LEN; i++) begin
      x = lehmer(x);
      w = 64'(x) << 40;
      x = lehmer(x);
      w ^= 64'(x) << 20;
      x = lehmer(x);
      w ^= 64'(x);
      lag_ring[i] = word_t'(w ^ 64'(WARM_ROM[i]));
    end
  endtask

  function automatic ptr_t step_back(input ptr_t p);
    return (p == 0) ? ptr_t'(RING_LEN - 1) : ptr_t'(p - 1'b1);
  endfunction

  function automatic word_t next_draw();
    word_t sum;
    tap_ptr  = step_back(tap_ptr);
    feed_ptr = step_back(feed_ptr);
    sum = lag_ring[feed_ptr] + lag_ring[tap_ptr];
    lag_ring[feed_ptr] = sum;
    return sum;
  endfunction

  // mostly short gaps, a few long ones, and now and then a gap-free stretch
  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm = $urandom_range(40, 160);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_req(input lfg_req_t kind, input logic [SEED_W-1:0] seed);
    req_item_t item;
    item.kind = kind;
    item.seed = seed;
    request_q.push_back(item);
  endfunction

  function automatic logic [SEED_W-1:0] rand_seed();
    logic [63:0] k;
    k = 64'($urandom_range(1, 1000));
    unique case ($urandom_range(0, 7))
      0:       return k * 64'(LEH_MOD);
      1:       return 64'd0 - k * 64'(LEH_MOD);
      2:       return 64'd0 - 64'($urandom);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // sample both channels, check results, advance the ring model
  always @(posedge clk) begin : watch_channels
    word_t want;
    in_took  = rst_n && in_chan.valid && in_chan.ready;
    out_took = rst_n && out_chan.valid && out_chan.ready;
    if (out_took) begin
      if (pending_draws.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("unexpected transaction: random_value=%0d", out_chan.random_value);
      end else begin
        want = pending_draws.pop_front();
        if (want !== out_chan.random_value) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("random_value mismatch: expected %0d, actual %0d",
                     want, out_chan.random_value);
        end
      end
    end
    if (in_took) begin
      n_in_taken++;
      if (in_chan.req_type == REQ_DRAW) pending_draws.push_back(next_draw());
      else reload_ring(in_chan.seed_value);
    end
    if (in_took || out_took) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin : drive_requests
    req_item_t item;
    if (rst_n && (!in_chan.valid || in_took)) begin
      if (send_gap > 0 || request_q.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_chan.valid <= 1'b0;
      end else begin
        item = request_q.pop_front();
        in_chan.valid      <= 1'b1;
        in_chan.req_type   <= item.kind;
        in_chan.seed_value <= item.seed;
        send_gap = pick_gap(send_calm);
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (!hold_done && out_took && n_in_taken >= 400 &&
                   in_chan.valid && in_chan.req_type == REQ_DRAW) begin
        // long hold-off while draws keep coming: result buffer fills, input stalls
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_chan.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        rx_stall = pick_gap(rx_calm);
      end
    end
  end

  initial begin : stimulus
    int  run_len;
    bit  first_run;
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.req_type   = REQ_SEED;
    in_chan.seed_value = '0;
    out_chan.ready     = 1'b0;
    err_cnt     = 0;
    n_in_taken  = 0;
    idle_cycles = 0;
    in_took     = 1'b0;
    out_took    = 1'b0;
    send_gap    = 0;
    send_calm   = 0;
    rx_stall    = 0;
    rx_calm     = 0;
    hold_left   = 0;
    hold_done   = 1'b0;

    // directed: zero seed, seeds whose residue is zero, sign extremes
    queue_req(REQ_SEED, 64'd0);
    queue_req(REQ_DRAW, '1);
    queue_req(REQ_DRAW, 64'd0);
    queue_req(REQ_SEED, 64'(LEH_MOD));
    queue_req(REQ_DRAW, 64'd0);
    queue_req(REQ_SEED, 64'd0 - 64'(LEH_MOD));
    queue_req(REQ_DRAW, 64'd0);
    queue_req(REQ_SEED, 64'h8000_0000_0000_0000);
    queue_req(REQ_DRAW, 64'd0);
    queue_req(REQ_SEED, 64'h7FFF_FFFF_FFFF_FFFF);
    queue_req(REQ_DRAW, 64'd0);
    queue_req(REQ_SEED, '1);
    queue_req(REQ_DRAW, 64'd0);
    queue_req(REQ_SEED, 64'd1);
    queue_req(REQ_SEED, 64'(LEH_MOD) - 64'd1);
    queue_req(REQ_DRAW, 64'd0);
    queue_req(REQ_DRAW, '1);

    // random: reseed then a run of draws; the first run wraps both pointers
    first_run = 1'b1;
    while (request_q.size() < N_ITEMS) begin
      queue_req(REQ_SEED, rand_seed());
      if (first_run) run_len = $urandom_range(620, 700);
      else if ($urandom_range(0, 9) == 0) run_len = 0;
      else run_len = $urandom_range(20, 250);
      first_run = 1'b0;
      repeat (run_len) queue_req(REQ_DRAW, {$urandom, $urandom});
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_chan.valid) @(negedge clk);
    while (pending_draws.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    if (err_cnt == 0 && pending_draws.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
